FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/lpsw_pkg.sv
// ----------------------------------------------------------------------------
// lpsw_pkg
// Types and constants of the page-shadow pixel writer.
// ----------------------------------------------------------------------------
package lpsw_pkg;

  localparam int PAGES = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Display command opcodes
  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] COL_LO_CMD = 8'h00;
  localparam logic [7:0] COL_HI_CMD = 8'h10;
  localparam logic [7:0] TOP_BIT    = 8'h80;

  // Beat order within one pixel's run
  localparam logic [1:0] BEAT_PAGE   = 2'd0;
  localparam logic [1:0] BEAT_COL_LO = 2'd1;
  localparam logic [1:0] BEAT_COL_HI = 2'd2;
  localparam logic [1:0] BEAT_DATA   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

FILE: rtl/lcd_page_shadow_pixel_writer.sv
// ----------------------------------------------------------------------------
// lcd_page_shadow_pixel_writer
// Sets or clears one pixel in a shadow framebuffer and emits the LCD bytes.
// ----------------------------------------------------------------------------
// Input beat (in_*): one pixel, column/row/pixel_on. Columns at or beyond
// COLUMNS are taken and dropped without any output.
// Output beats (out_*): four per pixel, in order: page command, column-low
// command, column-high command, updated shadow byte. out_tuser marks the
// data byte, out_tdata[8] is set on every beat but the column-low, out_tlast the fourth.
// The shadow store is one synchronous RAM of COLUMNS*8 bytes; it is read on
// the input beat and written back in the following cycle.
// The page command appears the cycle after the input beat, and the data byte
// follows the two column commands.
// Pixels are paced by the four output beats on the one output channel; the
// next pixel is taken together with the final beat.
// Reset: a clearing pass writes zero to every shadow byte, during which
// in_tready stays low.
// Stall: while out_tready is low the current beat holds and no new pixel is
// taken.
// ----------------------------------------------------------------------------
module lcd_page_shadow_pixel_writer #(
  parameter int COLUMNS = 102
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [6:0] column, [12:7] row, [13] pixel_on, [15:14] zero
  input  logic [lpsw_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] out_byte, [8] transfer_end, [15:9] zero
  output logic [lpsw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] is_data
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import lpsw_pkg::*;

  `include "assert_macros.svh"

  localparam int Depth = COLUMNS * PAGES;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_addr_r;
  logic [1:0]     beat_r, beat_nxt;
  logic           wb_pend_r;

  logic [6:0]     col_r;
  logic [2:0]     page_r;
  logic [7:0]     bit_r;
  logic           on_r;
  logic [AW-1:0]  addr_r;
  logic [7:0]     rd_data_r;
  logic [7:0]     cell_r;

  logic [7:0]     shadow_mem [Depth];

  logic [6:0]     in_col;
  logic [5:0]     in_row;
  logic           in_on;
  logic           in_acc;
  logic           col_ok;
  logic [AW-1:0]  in_addr;
  logic           out_acc;
  logic           last_beat_acc;
  logic [7:0]     cell_nxt;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [7:0]     out_byte;

  assign in_col = in_tdata[6:0];
  assign in_row = in_tdata[12:7];
  assign in_on  = in_tdata[13];

  assign col_ok  = (32'(in_col) < COLUMNS);
  assign in_addr = AW'(32'(in_row[5:3]) * COLUMNS + 32'(in_col));

  assign out_tvalid    = (state_r == ST_EMIT);
  assign out_acc       = out_tvalid && out_tready;
  assign last_beat_acc = out_acc && (beat_r == BEAT_DATA);

  // Take the next pixel together with the final beat of the current one
  assign in_tready = (state_r == ST_IDLE) || last_beat_acc;
  assign in_acc    = in_tvalid && in_tready;

  assign cell_nxt = on_r ? (rd_data_r | bit_r) : (rd_data_r & ~bit_r);

  always_comb begin
    state_nxt = state_r;
    beat_nxt  = beat_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(Depth - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && col_ok) begin
          state_nxt = ST_EMIT;
          beat_nxt  = BEAT_PAGE;
        end
      end
      ST_EMIT: begin
        if (in_acc && col_ok) begin
          beat_nxt = BEAT_PAGE;
        end else if (last_beat_acc) begin
          state_nxt = ST_IDLE;
        end else if (out_acc) begin
          beat_nxt = beat_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      beat_r     <= BEAT_PAGE;
      wb_pend_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      beat_r    <= beat_nxt;
      wb_pend_r <= in_acc && col_ok;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // Pixel fields, held for the four beats
  always_ff @(posedge clk) begin
    if (in_acc && col_ok) begin
      col_r  <= in_col;
      page_r <= in_row[5:3];
      bit_r  <= TOP_BIT >> in_row[2:0];
      on_r   <= in_on;
      addr_r <= in_addr;
    end
    if (wb_pend_r) begin
      cell_r <= cell_nxt;
    end
  end

  // Single write port: clearing pass or write-back of the modified byte
  assign mem_we    = (state_r == ST_CLEAR) || wb_pend_r;
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_addr_r : addr_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? 8'h00 : cell_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc && col_ok) begin
      rd_data_r <= shadow_mem[in_addr];
    end
  end

  always_comb begin
    case (beat_r)
      BEAT_PAGE:   out_byte = PAGE_CMD | {5'b0, 3'(PAGES - 1) - page_r};
      BEAT_COL_LO: out_byte = COL_LO_CMD | {4'b0, col_r[3:0]};
      BEAT_COL_HI: out_byte = COL_HI_CMD | {5'b0, col_r[6:4]};
      BEAT_DATA:   out_byte = cell_r;
      default:     out_byte = 8'h00;
    endcase
  end

  assign out_tdata = {7'b0, (beat_r != BEAT_COL_LO), out_byte};
  assign out_tuser = (beat_r == BEAT_DATA);
  assign out_tlast = (beat_r == BEAT_DATA);

  `ASSERT_IMPLY(a_no_take_in_clear, clk, rst_n, state_r == ST_CLEAR, !in_tready)
  `ASSERT_NEXT(a_run_starts_at_page, clk, rst_n, in_acc && col_ok,
               out_tvalid && (beat_r == BEAT_PAGE) && wb_pend_r)
  `ASSERT_IMPLY(a_wb_on_first_beat, clk, rst_n, wb_pend_r,
                (state_r == ST_EMIT) && (beat_r == BEAT_PAGE))
  `ASSERT_NEXT(a_stall_holds_beat, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(beat_r))
  `ASSERT_IMPLY(a_dropped_col_no_run, clk, rst_n,
                in_acc && !col_ok && (state_r == ST_IDLE), state_nxt == ST_IDLE)

endmodule
